// ===== rtl/alps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the averaged level-percent sensor.
// No dependencies; used by alps_div and averaged_level_percent_sensor.
package alps_pkg;

  localparam int unsigned ADC_W = 12;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned SUM_W = 18;
  localparam int unsigned DIV_W = 19;
  localparam int unsigned DVS_W = 12;
  localparam int unsigned IDX_W = 2;

  // Mean by reciprocal: shift covers the sum width plus log2 of the largest group.
  localparam int unsigned AVG_SHIFT  = SUM_W + 6;
  localparam int unsigned AVG_PROD_W = SUM_W + AVG_SHIFT + 1;

  // Divide by 100 by reciprocal: exact for products up to 100 * 100.
  localparam int unsigned PROD_W    = 2 * PCT_W;
  localparam int unsigned SCL_W     = 27;
  localparam int unsigned PCT_SHIFT = 19;
  localparam logic [12:0] PCT_RECIP = 13'd5243;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [ADC_W-1:0] EMPTY_RESET = 12'd0;
  localparam logic [ADC_W-1:0] FULL_RESET = 12'd4095;
  localparam logic [PCT_W-1:0] FLOOR_RESET = 7'd50;
  localparam logic [PCT_W-1:0] THRESH_RESET = 7'd20;

  typedef enum logic [IDX_W-1:0] {
    REG_EMPTY = 2'd0,
    REG_FULL = 2'd1,
    REG_FLOOR = 2'd2,
    REG_THRESH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/alps_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on alps_pkg for widths and the request/response structs.
module alps_div (
  input  logic                clk,
  input  logic                rst,
  input  alps_pkg::div_req_t  req,
  output alps_pkg::div_rsp_t  rsp
);

  localparam int unsigned CNT_W = $clog2(alps_pkg::DIV_W);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [alps_pkg::DIV_W-1:0]  quo;
  logic [alps_pkg::DVS_W-1:0]  rem;
  logic [alps_pkg::DVS_W-1:0]  dvs;

  logic [alps_pkg::DVS_W:0]    shifted;
  logic [alps_pkg::DVS_W:0]    diff;
  logic                        ge;
  logic [alps_pkg::DVS_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[alps_pkg::DIV_W-1]};
    diff     = shifted - {1'b0, dvs};
    ge       = !diff[alps_pkg::DVS_W];
    rem_next = ge ? diff[alps_pkg::DVS_W-1:0] : shifted[alps_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(alps_pkg::DIV_W - 1);
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        quo <= {quo[alps_pkg::DIV_W-2:0], ge};
        rem <= rem_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/averaged_level_percent_sensor.sv =====
`timescale 1ns / 1ps
// Top level: sample accumulator, calibration registers and the sequencer
// around the shared divider. Depends on alps_pkg and alps_div.

// Each request carries one 12-bit ADC sample. Samples that do not close a
// group are taken one per cycle and give no result. The sample that closes a
// group of SAMPLES starts the sequencer: the mean by reciprocal multiplication,
// a range check, the sensor map on the shared serial divider and the taking of
// its quotient, the display rescale by reciprocal multiplication and the load
// of the result. in_ready stays low from that request until the result is
// loaded; the divider is skipped when the mean lies on or outside the
// calibration window or the calibration is faulty, and the wait is longer
// while the previous result still waits in the output register. A finished
// result waits there while new samples are accepted. Write the calibration
// registers only while idle.
module averaged_level_percent_sensor #(
  parameter int unsigned SAMPLES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [alps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [alps_pkg::ADC_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [alps_pkg::ADC_W-1:0]  sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [alps_pkg::ADC_W-1:0]  average,
  output logic [alps_pkg::PCT_W-1:0]  sensor_pct,
  output logic [alps_pkg::PCT_W-1:0]  level_pct,
  output logic                        has_water,
  output logic                        calib_fault
);

  localparam int unsigned CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned AVG_RECIP = ((1 << alps_pkg::AVG_SHIFT) + SAMPLES - 1) / SAMPLES;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_AVG  = 7'b0000010,
    S_PREP = 7'b0000100,
    S_MAP  = 7'b0001000,
    S_LVL  = 7'b0010000,
    S_LVLW = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                       state;
  logic [alps_pkg::ADC_W-1:0]   empty_level;
  logic [alps_pkg::ADC_W-1:0]   full_level;
  logic [alps_pkg::PCT_W-1:0]   floor_pct;
  logic [alps_pkg::PCT_W-1:0]   low_threshold;
  logic [alps_pkg::SUM_W-1:0]   sum;
  logic [CNT_W-1:0]             count;
  logic [alps_pkg::ADC_W-1:0]   avg;
  logic [alps_pkg::PCT_W-1:0]   sensor;
  logic [alps_pkg::PCT_W-1:0]   level;
  logic [alps_pkg::PROD_W-1:0]  lvl_prod;

  logic [alps_pkg::SUM_W-1:0]   sum_add;
  logic [alps_pkg::AVG_PROD_W-1:0] avg_prod;
  logic [alps_pkg::SCL_W-1:0]   lvl_scaled;
  logic                         last;
  logic                         fault;
  logic [alps_pkg::PCT_W-1:0]   flr;
  logic                         out_free;
  alps_pkg::div_req_t           div_req;
  alps_pkg::div_rsp_t           div_rsp;

  alps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    sum_add    = sum + alps_pkg::SUM_W'(sample);
    avg_prod   = alps_pkg::AVG_PROD_W'(sum) * alps_pkg::AVG_PROD_W'(AVG_RECIP);
    lvl_scaled = alps_pkg::SCL_W'(lvl_prod) * alps_pkg::SCL_W'(alps_pkg::PCT_RECIP);
    last       = (count == CNT_W'(SAMPLES - 1));
    fault      = (full_level <= empty_level);
    flr        = (floor_pct > alps_pkg::PCT_FULL) ? alps_pkg::PCT_FULL : floor_pct;
    out_free   = !out_valid || out_ready;
    in_ready   = (state == S_IDLE);
  end

  always_comb begin
    div_req = '0;
    unique case (state)
      S_PREP: begin
        if (!fault && avg > empty_level && avg < full_level) begin
          div_req.start    = 1'b1;
          div_req.dividend = alps_pkg::DIV_W'(avg - empty_level)
                             * alps_pkg::DIV_W'(alps_pkg::PCT_FULL);
          div_req.divisor  = full_level - empty_level;
        end
      end
      S_IDLE, S_AVG, S_MAP, S_LVL, S_LVLW, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_level   <= alps_pkg::EMPTY_RESET;
      full_level    <= alps_pkg::FULL_RESET;
      floor_pct     <= alps_pkg::FLOOR_RESET;
      low_threshold <= alps_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (alps_pkg::reg_idx_t'(cfg_index))
        alps_pkg::REG_EMPTY:  empty_level   <= cfg_data;
        alps_pkg::REG_FULL:   full_level    <= cfg_data;
        alps_pkg::REG_FLOOR:  floor_pct     <= cfg_data[alps_pkg::PCT_W-1:0];
        alps_pkg::REG_THRESH: low_threshold <= cfg_data[alps_pkg::PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sum <= sum_add;
            if (last) begin
              count <= '0;
              state <= S_AVG;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        S_AVG: begin
          avg   <= avg_prod[alps_pkg::AVG_SHIFT +: alps_pkg::ADC_W];
          sum   <= '0;
          state <= S_PREP;
        end
        S_PREP: begin
          if (fault || avg <= empty_level) begin
            sensor <= '0;
            state  <= S_LVL;
          end else if (avg >= full_level) begin
            sensor <= alps_pkg::PCT_FULL;
            state  <= S_LVL;
          end else begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          if (div_rsp.done) begin
            sensor <= div_rsp.quotient[alps_pkg::PCT_W-1:0];
            state  <= S_LVL;
          end
        end
        S_LVL: begin
          lvl_prod <= alps_pkg::PROD_W'(sensor)
                      * alps_pkg::PROD_W'(alps_pkg::PCT_FULL - flr);
          state    <= S_LVLW;
        end
        S_LVLW: begin
          level <= flr + lvl_scaled[alps_pkg::PCT_SHIFT +: alps_pkg::PCT_W];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            average     <= avg;
            sensor_pct  <= sensor;
            level_pct   <= level;
            has_water   <= (level > low_threshold);
            calib_fault <= fault;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
